// ----- design/tcw_pkg.sv -----
// Shared types and constants for the text console writer.
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int ACTION_W = 2;
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int CELL_W   = 16;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [CHAR_W-1:0] BLANK_ATTR   = 8'h07;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [CHAR_W-1:0]   char_code;
    logic [INDEX_W-1:0]  cell_index;
  } req_beat_t;

  typedef struct packed {
    logic [INDEX_W-1:0] cursor_pos;
    logic [CELL_W-1:0]  read_data;
    logic               scrolled;
  } rsp_beat_t;

endpackage

// ----- design/text_console_writer.sv -----
// Text console writer: cell store, cursor, scroll and clear sequencer.
//
//   channel | signals                     | direction | moves
//   req     | req_valid, req_ready, req   | in        | one action beat
//   rsp     | rsp_valid, rsp_ready, rsp   | out       | one result beat per action
//   color   | color_we, color_data        | in        | attribute register write
//
// A put or newline goes straight to its result; a read adds one registered store read.
// A clear, and a put or newline that scrolls, walk every cell once on the single store write port.
// After reset the store is blanked, one cell after another, with req_ready low.
// A waiting result beat stalls only the final ST_FINISH step of the next action.
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  tcw_pkg::req_beat_t          req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output tcw_pkg::rsp_beat_t          rsp,
  input  logic                        color_we,
  input  logic [tcw_pkg::CHAR_W-1:0]  color_data
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int LAST  = CELLS - COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CLW   = $clog2(COLUMNS + 1);
  localparam int CMP_W = (AW > tcw_pkg::INDEX_W) ? AW + 1 : tcw_pkg::INDEX_W + 1;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_READ   = 6'b000100,
    ST_SCROLL = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t                        state;
  logic [AW-1:0]                 sweep;
  logic                          clear_reply;
  logic [RW-1:0]                 row;
  logic [CLW-1:0]                col;
  logic [AW-1:0]                 row_base;
  logic [tcw_pkg::CHAR_W-1:0]    text_color;
  logic [tcw_pkg::CELL_W-1:0]    res_rdata;
  logic                          res_scrolled;
  logic                          read_hit;
  logic                          pipe_valid;
  logic                          pipe_src;
  logic [AW-1:0]                 pipe_addr;

  logic [tcw_pkg::CELL_W-1:0]    cells [CELLS];
  logic [tcw_pkg::CELL_W-1:0]    rd_data;

  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [tcw_pkg::CELL_W-1:0]    mem_wdata;
  logic [AW-1:0]                 mem_raddr;

  logic                          accept;
  logic                          at_last_row;
  logic                          at_last_col;
  logic                          is_newline;
  logic                          wrap;
  logic                          sweep_done;
  logic [AW-1:0]                 pos;
  logic [AW:0]                   src_addr;
  logic                          in_range;
  logic                          rsp_free;

  assign req_ready   = (state == ST_IDLE);
  assign accept      = req_valid && req_ready;
  assign at_last_row = (row == RW'(ROWS - 1));
  assign at_last_col = (col == CLW'(COLUMNS - 1));
  assign is_newline  = (req.char_code == tcw_pkg::NEWLINE_CODE);
  assign wrap        = is_newline || at_last_col;
  assign sweep_done  = (sweep == AW'(CELLS - 1));
  assign pos         = row_base + AW'(col);
  assign src_addr    = {1'b0, sweep} + (AW + 1)'(COLUMNS);
  assign in_range    = (CMP_W'(req.cell_index) < CMP_W'(CELLS));
  assign rsp_free    = !rsp_valid || rsp_ready;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos;
    mem_wdata = {text_color, req.char_code};
    mem_raddr = AW'(req.cell_index);
    if (pipe_valid) begin
      mem_we    = 1'b1;
      mem_waddr = pipe_addr;
      mem_wdata = pipe_src ? rd_data : {text_color, tcw_pkg::SPACE_CODE};
    end else if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = sweep;
      mem_wdata = {tcw_pkg::BLANK_ATTR, tcw_pkg::SPACE_CODE};
    end else if (accept && req.action == tcw_pkg::ACT_PUT && !is_newline) begin
      mem_we = 1'b1;
    end
    if (state == ST_SCROLL) begin
      mem_raddr = src_addr[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells[mem_waddr] <= mem_wdata;
    end
    rd_data <= cells[mem_raddr];
  end

  always_ff @(posedge clk) begin
    pipe_addr <= sweep;
    pipe_src  <= (int'(sweep) < LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      sweep        <= '0;
      clear_reply  <= 1'b0;
      row          <= '0;
      col          <= '0;
      row_base     <= '0;
      text_color   <= tcw_pkg::BLANK_ATTR;
      res_rdata    <= '0;
      res_scrolled <= 1'b0;
      read_hit     <= 1'b0;
      pipe_valid   <= 1'b0;
      rsp_valid    <= 1'b0;
      rsp          <= '0;
    end else begin
      if (color_we) begin
        text_color <= color_data;
      end
      pipe_valid <= (state == ST_SCROLL);
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          sweep <= sweep + AW'(1);
          if (sweep_done) begin
            sweep <= '0;
            state <= clear_reply ? ST_FINISH : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            res_rdata    <= '0;
            res_scrolled <= 1'b0;
            read_hit     <= in_range;
            sweep        <= '0;
            state        <= ST_FINISH;
            case (req.action)
              tcw_pkg::ACT_PUT: begin
                if (wrap) begin
                  col <= '0;
                  if (at_last_row) begin
                    res_scrolled <= 1'b1;
                    state        <= ST_SCROLL;
                  end else begin
                    row      <= row + RW'(1);
                    row_base <= row_base + AW'(COLUMNS);
                  end
                end else begin
                  col <= col + CLW'(1);
                end
              end
              tcw_pkg::ACT_CLEAR: begin
                row         <= '0;
                col         <= '0;
                row_base    <= '0;
                clear_reply <= 1'b1;
                state       <= ST_CLEAR;
              end
              tcw_pkg::ACT_READ: begin
                state <= ST_READ;
              end
              default: begin
                state <= ST_FINISH;
              end
            endcase
          end
        end
        ST_READ: begin
          if (read_hit) begin
            res_rdata <= rd_data;
          end
          state <= ST_FINISH;
        end
        ST_SCROLL: begin
          sweep <= sweep + AW'(1);
          if (sweep_done) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (rsp_free) begin
            rsp_valid          <= 1'b1;
            rsp.cursor_pos     <= tcw_pkg::INDEX_W'(pos);
            rsp.read_data      <= res_rdata;
            rsp.scrolled       <= res_scrolled;
            clear_reply        <= 1'b0;
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    (int'(row) < ROWS) && (int'(col) < COLUMNS))
    else $error("cursor outside the screen");

  a_row_base_match: assert property (@(posedge clk) disable iff (rst)
    int'(row_base) == int'(row) * COLUMNS)
    else $error("row base out of step with cursor row");

  a_scroll_on_last_row: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.scrolled |-> rsp.cursor_pos == tcw_pkg::INDEX_W'(LAST))
    else $error("scroll reported off the last row");

  a_pipe_in_scroll: assert property (@(posedge clk) disable iff (rst)
    pipe_valid |-> (state == ST_SCROLL) || (state == ST_DRAIN))
    else $error("scroll write outside the scroll sweep");
`endif

endmodule

// ----- verif/tcw_console_checker.sv -----
// Checker for the text console writer: models the screen, predicts each result beat, compares.
module tcw_console_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic                       req_ready,
  input  tcw_pkg::req_beat_t         req,
  input  logic                       rsp_valid,
  input  logic                       rsp_ready,
  input  tcw_pkg::rsp_beat_t         rsp,
  input  logic                       color_we,
  input  logic [tcw_pkg::CHAR_W-1:0] color_data,
  output int                         fail_count,
  output int                         outstanding,
  output int                         scroll_count
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  logic [CELL_W-1:0] cells [CELLS];
  int unsigned       cur_row;
  int unsigned       cur_col;
  logic [CHAR_W-1:0] text_attr;
  rsp_beat_t         due_results [$];
  int                mismatches;
  int                scrolls;

  assign fail_count   = mismatches;
  assign scroll_count = scrolls;

  task automatic report_mismatch(input string what);
    $display("%0t: MISMATCH %s", $time, what);
    mismatches++;
  endtask

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) cells[i] = {BLANK_ATTR, SPACE_CODE};
    cur_row = 0;
    cur_col = 0;
  endfunction

  function automatic logic next_row();
    cur_row++;
    if (cur_row < ROWS) return 1'b0;
    for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) cells[i] = cells[i + COLUMNS];
    for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) cells[i] = {text_attr, SPACE_CODE};
    cur_row = ROWS - 1;
    scrolls++;
    return 1'b1;
  endfunction

  function automatic rsp_beat_t console_step(input req_beat_t b);
    rsp_beat_t   r;
    int unsigned pos;
    r = '0;
    case (action_t'(b.action))
      ACT_PUT: begin
        if (b.char_code == NEWLINE_CODE) begin
          r.scrolled = next_row();
          cur_col = 0;
        end else begin
          pos = cur_row * COLUMNS + cur_col;
          if (pos < CELLS) cells[pos] = {text_attr, b.char_code};
          cur_col++;
          if (cur_col >= COLUMNS) begin
            cur_col = 0;
            r.scrolled = next_row();
          end
        end
      end
      ACT_CLEAR: begin
        blank_screen();
      end
      ACT_READ: begin
        if (b.cell_index < CELLS) r.read_data = cells[b.cell_index];
      end
      default: begin
      end
    endcase
    r.cursor_pos = INDEX_W'(cur_row * COLUMNS + cur_col);
    return r;
  endfunction

  initial begin
    mismatches = 0;
    scrolls    = 0;
    outstanding = 0;
    text_attr  = BLANK_ATTR;
    blank_screen();
  end

  always @(posedge clk) begin
    rsp_beat_t want;
    if (rst) begin
      blank_screen();
      text_attr = BLANK_ATTR;
      due_results.delete();
      outstanding <= 0;
    end else begin
      if (req_valid && req_ready) due_results.push_back(console_step(req));
      if (rsp_valid && rsp_ready) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result beat with none expected: %h", rsp));
        end else begin
          want = due_results.pop_front();
          if (rsp.cursor_pos !== want.cursor_pos)
            report_mismatch($sformatf("cursor_pos got %0d want %0d",
                                      rsp.cursor_pos, want.cursor_pos));
          if (rsp.read_data !== want.read_data)
            report_mismatch($sformatf("read_data got %h want %h",
                                      rsp.read_data, want.read_data));
          if (rsp.scrolled !== want.scrolled)
            report_mismatch($sformatf("scrolled got %b want %b",
                                      rsp.scrolled, want.scrolled));
        end
      end
      if (color_we) text_attr = color_data;
      outstanding <= due_results.size();
    end
  end

endmodule

// ----- verif/tb_text_console_writer.sv -----
// Testbench top for the text console writer: clock, reset, stimulus, pacing and verdict.
module tb_text_console_writer;
  import tcw_pkg::*;

  localparam int CELLS       = COLUMNS_DEF * ROWS_DEF;
  localparam int QUIET_LIMIT = 20000;
  localparam int SEG_BEATS   = 115;

  logic              clk = 1'b0;
  logic              rst;
  logic              req_valid;
  logic              req_ready;
  req_beat_t         req;
  logic              rsp_valid;
  logic              rsp_ready;
  rsp_beat_t         rsp;
  logic              color_we;
  logic [CHAR_W-1:0] color_data;

  int fail_count;
  int outstanding;
  int scroll_count;
  int send_gap_pct;
  int rsp_stall_pct;
  int beats_sent;
  int colors_written;
  int line_left;
  int quiet_cycles;
  int send_idle [3] = '{21, 49, 0};
  int rsp_idle  [3] = '{49, 21, 0};

  always #5 clk = ~clk;

  text_console_writer dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .color_we   (color_we),
    .color_data (color_data)
  );

  tcw_console_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .rsp          (rsp),
    .color_we     (color_we),
    .color_data   (color_data),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .scroll_count (scroll_count)
  );

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic req_beat_t pack_action(input action_t a, input logic [CHAR_W-1:0] c,
                                            input logic [INDEX_W-1:0] i);
    req_beat_t b;
    b.action     = a;
    b.char_code  = c;
    b.cell_index = i;
    return b;
  endfunction

  // mostly short lines ending in newline, some long enough to wrap
  function automatic req_beat_t random_beat();
    req_beat_t   b;
    int unsigned pick;
    pick         = $urandom_range(999);
    b.char_code  = CHAR_W'($urandom);
    b.cell_index = INDEX_W'($urandom);
    if (pick < 4) begin
      b.action = ACT_CLEAR;
    end else if (pick < 30) begin
      b.action = ACT_NONE;
    end else if (pick < 180) begin
      b.action = ACT_READ;
      if ($urandom_range(3) != 0) b.cell_index = INDEX_W'($urandom_range(CELLS - 1));
    end else begin
      b.action = ACT_PUT;
      if (line_left == 0) begin
        b.char_code = NEWLINE_CODE;
        pick = $urandom_range(99);
        if (pick < 70) line_left = $urandom_range(3);
        else if (pick < 95) line_left = $urandom_range(15, 4);
        else line_left = $urandom_range(170, 70);
      end else begin
        line_left--;
      end
    end
    return b;
  endfunction

  task automatic send_beat(input req_beat_t b);
    req       <= b;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    beats_sent++;
    while ($urandom_range(99) < send_gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_color(input logic [CHAR_W-1:0] value);
    wait_idle();
    color_we   <= 1'b1;
    color_data <= value;
    @(posedge clk);
    color_we <= 1'b0;
    colors_written++;
  endtask

  initial begin
    rst            = 1'b1;
    req_valid      = 1'b0;
    req            = '0;
    rsp_ready      = 1'b0;
    color_we       = 1'b0;
    color_data     = '0;
    beats_sent     = 0;
    colors_written = 0;
    line_left      = 0;
    quiet_cycles   = 0;
    send_gap_pct   = send_idle[0];
    rsp_stall_pct  = rsp_idle[0];
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_beat(pack_action(ACT_READ, 8'h00, 11'd0));
    send_beat(pack_action(ACT_READ, 8'hFF, INDEX_W'(CELLS - 1)));
    send_beat(pack_action(ACT_READ, 8'h00, INDEX_W'(CELLS)));
    send_beat(pack_action(ACT_READ, 8'h0A, 11'h7FF));
    send_beat(pack_action(ACT_NONE, 8'hFF, 11'h7FF));
    send_beat(pack_action(ACT_PUT, 8'h00, 11'h000));
    send_beat(pack_action(ACT_PUT, 8'hFF, 11'h7FF));
    send_beat(pack_action(ACT_PUT, NEWLINE_CODE, 11'h555));
    send_beat(pack_action(ACT_READ, 8'h00, 11'd0));
    send_beat(pack_action(ACT_READ, 8'h00, 11'd1));
    set_color(8'hFF);
    send_beat(pack_action(ACT_PUT, 8'h41, 11'h2AA));
    send_beat(pack_action(ACT_READ, 8'h00, INDEX_W'(COLUMNS_DEF)));
    set_color(8'h00);
    send_beat(pack_action(ACT_PUT, 8'h7A, 11'h000));
    send_beat(pack_action(ACT_READ, 8'h00, INDEX_W'(COLUMNS_DEF + 1)));
    send_beat(pack_action(ACT_CLEAR, 8'hFF, 11'h7FF));
    send_beat(pack_action(ACT_READ, 8'h00, 11'd0));
    send_beat(pack_action(ACT_PUT, 8'h71, 11'h000));
    send_beat(pack_action(ACT_READ, 8'h00, 11'd0));

    for (int phase = 0; phase < 3; phase++) begin
      wait_idle();
      send_gap_pct  = send_idle[phase];
      rsp_stall_pct = rsp_idle[phase];
      for (int seg = 0; seg < 4; seg++) begin
        case (seg)
          0: begin
            set_color(8'hFF);
          end
          1: begin
            set_color(8'h00);
          end
          default: begin
            set_color(CHAR_W'($urandom));
          end
        endcase
        for (int n = 0; n < SEG_BEATS; n++) send_beat(random_beat());
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Covered %0d action beats, %0d color writes and %0d scrolls", beats_sent,
             colors_written, scroll_count);
    $display("Pacing: sender/receiver idle 21/49, then 49/21, then none");
    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
